// ===== rtl/core/drl_pkg.sv =====
// Shared types and constants of the Doppler linear resampler.
// Holds field widths, reset values, item opcodes, register indexes, and configuration and status structs.
// No dependencies.
`default_nettype none

package drl_pkg;

    // Fixed widths of the item and register fields.
    localparam int POS_BITS        = 12;
    localparam int RATIO_BITS      = 32;
    localparam int COUNT_BITS      = 13;
    localparam int FRAC_BITS       = 16;
    localparam int RATIO_FRAC_BITS = 30;

    // Register reset values: a full frame and a ratio of exactly one.
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 13'd4096;
    localparam logic [RATIO_BITS-1:0] RATIO_RESET = 32'h4000_0000;

    // Item opcodes.
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } drl_op_t;

    // Register indexes on the configuration port.
    typedef enum logic {
        REG_SAMPLE_COUNT = 1'b0,
        REG_RATE_RATIO   = 1'b1
    } drl_reg_t;

    // Configuration seen by the front end.
    typedef struct packed {
        logic [COUNT_BITS-1:0] sample_count;
        logic [RATIO_BITS-1:0] rate_ratio;
    } drl_cfg_t;

    // Activity of a front or back part.
    typedef struct packed {
        logic busy;
        logic fetch;
    } drl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/doppler_linear_resampler.sv =====
// Top level of the Doppler linear resampler: configuration registers and wiring.
// Depends on drl_pkg, drl_front, drl_queue, drl_back and drl_ram.
//
//   Channel  Direction  Handshake            Payload
//   s_       in         s_valid / s_ready    s_opcode, s_position, s_in_real, s_in_imag
//   m_       out        m_valid / m_ready    m_out_real, m_out_imag
//   APB      in         psel/penable/pready  paddr, pwdata, prdata
//
// The front end takes one item per cycle into its stage and a two-entry queue while
// the queue has room. In the back end a load is written in the idle state; a fetch
// runs ST_IDLE, ST_READ_B, ST_CALC, ST_ADD: two reads of the single-port sample
// memory, one multiply and one add. Commands are taken only in ST_IDLE. A result
// waits in the output register while the front keeps accepting items until the
// queue fills. Reset clears control state only; the sample memory is undefined until loaded.
`default_nettype none

module doppler_linear_resampler #(
    parameter int STORE_DEPTH = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [2:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_opcode,
    input  wire logic [drl_pkg::POS_BITS-1:0]        s_position,
    input  wire logic signed [SAMPLE_BITS-1:0]       s_in_real,
    input  wire logic signed [SAMPLE_BITS-1:0]       s_in_imag,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [SAMPLE_BITS-1:0]            m_out_real,
    output logic signed [SAMPLE_BITS-1:0]            m_out_imag
);

    import drl_pkg::*;

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int ENTRY_W = 2 + ADDR_W + FRAC_BITS + 2 * SAMPLE_BITS;

    logic [COUNT_BITS-1:0] sample_count_reg;
    logic [RATIO_BITS-1:0] rate_ratio_reg;
    drl_cfg_t              cfg;
    logic                  cfg_write;

    logic                  q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
    logic [ENTRY_W-1:0]    q_push_data, q_pop_data;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_addr;
    logic [2*SAMPLE_BITS-1:0] ram_wdata, ram_rdata;
    drl_stat_t             front_stat, back_stat;

    // Configuration port: writes in the access phase, reads from the registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= COUNT_RESET;
            rate_ratio_reg   <= RATIO_RESET;
        end else if (cfg_write) begin
            unique case (drl_reg_t'(paddr[2]))
                REG_SAMPLE_COUNT: sample_count_reg <= pwdata[COUNT_BITS-1:0];
                REG_RATE_RATIO:   rate_ratio_reg   <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (drl_reg_t'(paddr[2]))
            REG_SAMPLE_COUNT: prdata = 32'(sample_count_reg);
            REG_RATE_RATIO:   prdata = rate_ratio_reg;
        endcase
    end

    assign cfg.sample_count = sample_count_reg;
    assign cfg.rate_ratio   = rate_ratio_reg;

    // Front end.
    drl_front #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_position (s_position),
        .s_in_real  (s_in_real),
        .s_in_imag  (s_in_imag),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .stat       (front_stat)
    );

    // Command queue.
    drl_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    // Back end.
    drl_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data),
        .ram_we     (ram_we),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_real (m_out_real),
        .m_out_imag (m_out_imag),
        .stat       (back_stat)
    );

    // Sample memory, real part in the upper half of each entry.
    drl_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // An accepted fetch sits in the front stage on the next cycle.
    a_fetch_staged: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_opcode == OP_FETCH)) |=> front_stat.fetch
    ) else $error("accepted fetch item did not reach the front stage");

    // A result item appears only after the back end worked on a fetch.
    a_result_from_fetch: assert property (
        @(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(back_stat.fetch)
    ) else $error("result item appeared without a fetch in the back end");

    // With every part empty, no result item can appear.
    a_no_result_when_empty: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (!front_stat.busy && !q_pop_valid && !back_stat.busy) |=> !$rose(m_valid)
    ) else $error("result item appeared while the block was empty");

endmodule

`default_nettype wire

// ===== rtl/core/drl_ram.sv =====
// Generic single-port RAM with a registered read.
// One write or one read per cycle. No dependencies.
`default_nettype none

module drl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on request, otherwise read the addressed entry.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end else begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/drl_queue.sv =====
// Short command queue between the front end and the back end.
// Register based, first in first out. No dependencies.
`default_nettype none

module drl_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic      [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W:0]   FULL_CNT = (PTR_W + 1)'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/drl_front.sv =====
// Front end: accepts items, forms the source position and classifies each item.
// Pushes resolved commands into the queue, dropping loads outside the store. Depends on drl_pkg.
`default_nettype none

module drl_front #(
    parameter int STORE_DEPTH = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int ENTRY_W     = 2 + $clog2(STORE_DEPTH) + 16 + 2 * SAMPLE_BITS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire drl_pkg::drl_cfg_t                   cfg,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_opcode,
    input  wire logic [drl_pkg::POS_BITS-1:0]        s_position,
    input  wire logic signed [SAMPLE_BITS-1:0]       s_in_real,
    input  wire logic signed [SAMPLE_BITS-1:0]       s_in_imag,
    output logic                                     push_valid,
    input  wire logic                                push_ready,
    output logic [ENTRY_W-1:0]                       push_data,
    output drl_pkg::drl_stat_t                       stat
);

    import drl_pkg::*;

    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int PROD_BITS  = POS_BITS + RATIO_BITS;
    localparam int K_BITS     = PROD_BITS - RATIO_FRAC_BITS;
    localparam logic [31:0] DEPTH_32 = 32'(STORE_DEPTH);

    logic                          stage_valid_reg;
    drl_op_t                       op_reg;
    logic [POS_BITS-1:0]           pos_reg;
    logic [PROD_BITS-1:0]          prod_reg;
    logic signed [SAMPLE_BITS-1:0] re_reg, im_reg;

    logic                          accept;
    logic [K_BITS-1:0]             k_idx;
    logic [FRAC_BITS-1:0]          frac;
    logic [31:0]                   count_32, last_32;
    logic                          in_store, tail, need_push, step;
    logic [ADDR_W-1:0]             addr;
    logic [FRAC_BITS-1:0]          frac_out;

    // Integer and fraction parts of the source position.
    assign k_idx = prod_reg[PROD_BITS-1 -: K_BITS];
    assign frac  = prod_reg[RATIO_FRAC_BITS-1 -: FRAC_BITS];

    // Index of the last sample, with the count clamped to the store.
    always_comb begin
        count_32 = 32'(cfg.sample_count);
        if (count_32 == 32'd0) begin
            last_32 = 32'd0;
        end else if (count_32 > DEPTH_32) begin
            last_32 = DEPTH_32 - 32'd1;
        end else begin
            last_32 = count_32 - 32'd1;
        end
    end

    // Classify the staged item and resolve its memory address.
    always_comb begin
        in_store  = (32'(pos_reg) < DEPTH_32);
        tail      = (32'(k_idx) >= last_32);
        need_push = (op_reg == OP_FETCH) || in_store;
        step      = (op_reg == OP_FETCH) && !tail;
        if (op_reg == OP_LOAD) begin
            addr = ADDR_W'(pos_reg);
        end else if (tail) begin
            addr = ADDR_W'(last_32);
        end else begin
            addr = ADDR_W'(k_idx);
        end
        frac_out = step ? frac : '0;
    end

    assign push_valid = stage_valid_reg && need_push;
    assign push_data  = {op_reg, step, addr, frac_out, re_reg, im_reg};
    assign s_ready    = !stage_valid_reg || !need_push || push_ready;
    assign accept     = s_valid && s_ready;

    assign stat.busy  = stage_valid_reg;
    assign stat.fetch = stage_valid_reg && (op_reg == OP_FETCH);

    // Stage occupancy.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_ready) begin
            stage_valid_reg <= s_valid;
        end
    end

    // Stage payload, with the position product formed on the way in.
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= drl_op_t'(s_opcode);
            pos_reg  <= s_position;
            prod_reg <= PROD_BITS'(s_position) * PROD_BITS'(cfg.rate_ratio);
            re_reg   <= s_in_real;
            im_reg   <= s_in_imag;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/drl_back.sv =====
// Back end: carries out queued loads and fetches on the sample memory.
// Reads both neighbors, interpolates and holds the result item. Depends on drl_pkg.
`default_nettype none

module drl_back #(
    parameter int STORE_DEPTH = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int ENTRY_W     = 2 + $clog2(STORE_DEPTH) + 16 + 2 * SAMPLE_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          pop_valid,
    output logic                               pop_ready,
    input  wire logic [ENTRY_W-1:0]            pop_data,
    output logic                               ram_we,
    output logic [$clog2(STORE_DEPTH)-1:0]     ram_addr,
    output logic [2*SAMPLE_BITS-1:0]           ram_wdata,
    input  wire logic [2*SAMPLE_BITS-1:0]      ram_rdata,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_out_real,
    output logic signed [SAMPLE_BITS-1:0]      m_out_imag,
    output drl_pkg::drl_stat_t                 stat
);

    import drl_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int SB     = SAMPLE_BITS;
    localparam int PROD_W = FRAC_BITS + 1 + SB + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ_B,
        ST_CALC,
        ST_ADD
    } state_t;

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       addr_b_reg, addr_b_next;
    logic [FRAC_BITS-1:0]    frac_reg, frac_next;
    logic signed [SB-1:0]    a_re_reg, a_re_next, a_im_reg, a_im_next;
    logic signed [PROD_W-1:0] prod_re_reg, prod_re_next, prod_im_reg, prod_im_next;
    logic signed [SB-1:0]    out_re_reg, out_re_next, out_im_reg, out_im_next;
    logic                    m_valid_reg, m_valid_next;

    // Fields of the command at the head of the queue.
    logic                    cmd_op;
    logic                    cmd_step;
    logic [ADDR_W-1:0]       cmd_addr;
    logic [FRAC_BITS-1:0]    cmd_frac;
    logic [2*SB-1:0]         cmd_data;

    logic signed [SB-1:0]     rd_re, rd_im;
    logic signed [SB:0]       diff_re, diff_im;
    logic signed [FRAC_BITS:0] frac_s;
    logic signed [PROD_W-1:0] sh_re, sh_im, sum_re, sum_im;

    assign {cmd_op, cmd_step, cmd_addr, cmd_frac, cmd_data} = pop_data;
    assign rd_re = ram_rdata[2*SB-1 -: SB];
    assign rd_im = ram_rdata[SB-1:0];

    assign pop_ready = (state_reg == ST_IDLE);

    // Memory port: command address when idle, second neighbor otherwise.
    always_comb begin
        ram_we    = (state_reg == ST_IDLE) && pop_valid && (cmd_op == OP_LOAD);
        ram_addr  = (state_reg == ST_IDLE) ? cmd_addr : addr_b_reg;
        ram_wdata = cmd_data;
    end

    // Difference to the next sample, scaled by the fraction.
    always_comb begin
        frac_s       = {1'b0, frac_reg};
        diff_re      = (SB + 1)'(rd_re) - (SB + 1)'(a_re_reg);
        diff_im      = (SB + 1)'(rd_im) - (SB + 1)'(a_im_reg);
        prod_re_next = frac_s * diff_re;
        prod_im_next = frac_s * diff_im;
    end

    // Arithmetic shift of the product, added to the first sample.
    always_comb begin
        sh_re  = prod_re_reg >>> FRAC_BITS;
        sh_im  = prod_im_reg >>> FRAC_BITS;
        sum_re = PROD_W'(a_re_reg) + sh_re;
        sum_im = PROD_W'(a_im_reg) + sh_im;
    end

    // Sequencer next state.
    always_comb begin
        state_next   = state_reg;
        addr_b_next  = addr_b_reg;
        frac_next    = frac_reg;
        a_re_next    = a_re_reg;
        a_im_next    = a_im_reg;
        out_re_next  = out_re_reg;
        out_im_next  = out_im_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid && (cmd_op == OP_FETCH)) begin
                    addr_b_next = cmd_addr + ADDR_W'(cmd_step);
                    frac_next   = cmd_frac;
                    state_next  = ST_READ_B;
                end
            end
            ST_READ_B: begin
                a_re_next  = rd_re;
                a_im_next  = rd_im;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                state_next = ST_ADD;
            end
            ST_ADD: begin
                if (!m_valid_reg || m_ready) begin
                    out_re_next  = sum_re[SB-1:0];
                    out_im_next  = sum_im[SB-1:0];
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        addr_b_reg  <= addr_b_next;
        frac_reg    <= frac_next;
        a_re_reg    <= a_re_next;
        a_im_reg    <= a_im_next;
        prod_re_reg <= prod_re_next;
        prod_im_reg <= prod_im_next;
        out_re_reg  <= out_re_next;
        out_im_reg  <= out_im_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_real = out_re_reg;
    assign m_out_imag = out_im_reg;

    assign stat.busy  = (state_reg != ST_IDLE);
    assign stat.fetch = (state_reg != ST_IDLE);

endmodule

`default_nettype wire
